// ===== rtl/srsc_pkg.sv =====
// Shared types, codes and constants of the speed ramp setpoint controller.
`timescale 1ns / 1ps

package srsc_pkg;

    // Item kinds carried in the low bits of s_tuser.
    localparam logic [2:0] MODE_UPDATE   = 3'd0;
    localparam logic [2:0] MODE_SPEED    = 3'd1;
    localparam logic [2:0] MODE_ANGLE    = 3'd2;
    localparam logic [2:0] MODE_POLARITY = 3'd3;
    localparam logic [2:0] MODE_SNAPSHOT = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] REG_SPEED_LIMIT   = 2'd0;
    localparam logic [1:0] REG_RAMP_INTERVAL = 2'd1;

    localparam logic [14:0] SPEED_LIMIT_RESET   = 15'd255;
    localparam logic [15:0] RAMP_INTERVAL_RESET = 16'd1;

    localparam logic signed [16:0] DEADBAND   = 17'sd31;
    localparam logic signed [16:0] BIG_GAP    = 17'sd20;
    localparam logic signed [16:0] BIG_STEP   = 17'sd8;
    localparam logic signed [16:0] SMALL_STEP = 17'sd1;
    localparam logic signed [16:0] ANGLE_MAX  = 17'sd180;
    localparam logic signed [16:0] ANGLE_MIN  = -17'sd180;

    // Architectural state of the controller.
    typedef struct packed {
        logic signed [15:0] speed_now;
        logic signed [15:0] speed_goal;
        logic signed [8:0]  angle_now;
        logic               sign_negative;
        logic [31:0]        last_step_ms;
        logic signed [15:0] saved_speed;
        logic signed [8:0]  saved_angle;
    } state_t;

    // Configuration registers as seen by the update logic.
    typedef struct packed {
        logic [14:0] speed_limit;
        logic [15:0] ramp_interval;
    } cfg_t;

endpackage

// ===== rtl/srsc_step.sv =====
// Next-state logic for one item: clamp, deadband, polarity and speed ramp.
`timescale 1ns / 1ps

module srsc_step import srsc_pkg::*; (
    input  state_t             state_cur,
    input  cfg_t               cfg,
    input  logic [2:0]         mode,
    input  logic               source_ok,
    input  logic signed [15:0] command_value,
    input  logic [31:0]        now_ms,
    output state_t             state_new,
    output logic               changed
);

    logic signed [16:0] cmd_w;
    logic signed [16:0] lim_w;
    logic signed [16:0] speed_clamped;
    logic signed [16:0] speed_set;
    logic signed [16:0] angle_clamped;
    logic signed [16:0] angle_set;
    logic signed [16:0] gap;
    logic signed [16:0] gap_mag;
    logic signed [16:0] step;
    logic signed [16:0] speed_stepped;
    logic [31:0]        due_ms;
    logic               do_step;
    logic signed [15:0] goal_after_cmd;

    always_comb begin
        cmd_w = {command_value[15], command_value};
        lim_w = {2'b00, cfg.speed_limit};

        if (cmd_w > lim_w) begin
            speed_clamped = lim_w;
        end else if (cmd_w < -lim_w) begin
            speed_clamped = -lim_w;
        end else begin
            speed_clamped = cmd_w;
        end
        if (speed_clamped > -DEADBAND && speed_clamped < DEADBAND) begin
            speed_set = 17'sd0;
        end else begin
            speed_set = speed_clamped;
        end
        if (state_cur.sign_negative) begin
            speed_set = -speed_set;
        end

        if (cmd_w > ANGLE_MAX) begin
            angle_clamped = ANGLE_MAX;
        end else if (cmd_w < ANGLE_MIN) begin
            angle_clamped = ANGLE_MIN;
        end else begin
            angle_clamped = cmd_w;
        end
        angle_set = state_cur.sign_negative ? -angle_clamped : angle_clamped;

        state_new = state_cur;
        goal_after_cmd = state_cur.speed_goal;
        if (mode == MODE_SPEED && source_ok) begin
            goal_after_cmd = speed_set[15:0];
        end

        // The ramp sees a target written by the same item.
        gap     = {goal_after_cmd[15], goal_after_cmd}
                - {state_cur.speed_now[15], state_cur.speed_now};
        gap_mag = (gap < 0) ? -gap : gap;
        step    = (gap_mag > BIG_GAP) ? BIG_STEP : SMALL_STEP;
        speed_stepped = {state_cur.speed_now[15], state_cur.speed_now}
                      + ((gap > 0) ? step : -step);
        due_ms  = state_cur.last_step_ms + {16'd0, cfg.ramp_interval};
        do_step = (now_ms > due_ms) && (gap != 17'sd0);

        case (mode) inside
            MODE_UPDATE, MODE_SPEED, MODE_ANGLE: begin
                state_new.speed_goal = goal_after_cmd;
                if (mode == MODE_ANGLE && source_ok) begin
                    state_new.angle_now = angle_set[8:0];
                end
                if (do_step) begin
                    state_new.speed_now    = speed_stepped[15:0];
                    state_new.last_step_ms = now_ms;
                end
            end
            MODE_POLARITY: begin
                state_new.sign_negative = ~state_cur.sign_negative;
            end
            MODE_SNAPSHOT: begin
                state_new.saved_speed = state_cur.speed_now;
                state_new.saved_angle = state_cur.angle_now;
            end
            default: begin
                state_new = state_cur;
            end
        endcase

        changed = (state_new.speed_now != state_new.saved_speed)
               || (state_new.angle_now != state_new.saved_angle);
    end

endmodule

// ===== rtl/speed_ramp_setpoint_controller.sv =====
// Top level of the speed ramp setpoint controller with its stream and config ports.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid / s_tready  tdata: command_value, now_ms; tuser: mode, source_ok
// m_        out        m_tvalid / m_tready  tdata: current_speed, target_speed, current_angle,
//                                           changed
// cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each beat is captured in an input register; the update logic computes the new state from
// it, and the result register is loaded when it is empty or its beat is being taken, so a
// stalled result delays the result beat. One beat per cycle is sustained while m_tready is
// high. The state registers feed straight back into the update logic, so the next beat
// always sees the state left by the previous one.
// Reset (synchronous, aresetn low) clears all state to zero, polarity positive, and
// loads the configuration reset values. A stalled result holds the result register and
// the input register still takes one more beat; cfg_ready is always high.

module speed_ramp_setpoint_controller import srsc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [15:0] command_value, [47:16] now_ms
    input  logic [3:0]  s_tuser,   // [2:0] mode, [3] source_ok
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] current_speed, [31:16] target_speed,
                                   // [40:32] current_angle, [41] changed, rest zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // Configuration registers.
    cfg_t cfg_reg;

    // Input register stage.
    logic               in_valid_reg;
    logic [2:0]         in_mode_reg;
    logic               in_ok_reg;
    logic signed [15:0] in_cmd_reg;
    logic [31:0]        in_now_reg;

    // Controller state and result register.
    state_t      state_reg;
    state_t      state_next;
    logic        changed_next;
    logic        out_valid_reg;
    logic [47:0] out_data_reg;

    logic advance;

    assign cfg_ready = 1'b1;

    // The computed beat moves into the result register whenever that register is empty
    // or its contents are being taken this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_limit   <= SPEED_LIMIT_RESET;
            cfg_reg.ramp_interval <= RAMP_INTERVAL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SPEED_LIMIT:   cfg_reg.speed_limit   <= cfg_data[14:0];
                REG_RAMP_INTERVAL: cfg_reg.ramp_interval <= cfg_data;
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg <= s_tuser[2:0];
            in_ok_reg   <= s_tuser[3];
            in_cmd_reg  <= s_tdata[15:0];
            in_now_reg  <= s_tdata[47:16];
        end
    end

    srsc_step u_step (
        .state_cur     (state_reg),
        .cfg           (cfg_reg),
        .mode          (in_mode_reg),
        .source_ok     (in_ok_reg),
        .command_value (in_cmd_reg),
        .now_ms        (in_now_reg),
        .state_new     (state_next),
        .changed       (changed_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {6'd0, changed_next, state_next.angle_now,
                             state_next.speed_goal, state_next.speed_now};
        end
    end

    // The ramp never leaves the range spanned by the clamped targets.
    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] != 16'h8000))
        else $error("current_speed left its range");

    // Angles are always clamped to plus or minus 180.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[40:32]) <= 9'sd180
                   && $signed(m_tdata[40:32]) >= -9'sd180))
        else $error("current_angle left its range");

    // An empty result register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with the result register empty");

    // A snapshot result always reports no change.
    a_snapshot_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_mode_reg == MODE_SNAPSHOT) |=> !m_tdata[41])
        else $error("snapshot result reports a change");

endmodule
